FILE: design/cpi_pkg.sv
`default_nettype none

package cpi_pkg;

   localparam int COORD_W  = 32;
   localparam int NORM_W   = 16;
   localparam int RAD_W    = 31;
   localparam int NORM_FRAC = 14;
   localparam int PROD_W   = COORD_W + NORM_W;
   localparam int DIST_W   = PROD_W + 2;
   localparam int TWICE_W  = DIST_W + 3;
   localparam int PEN_W    = RAD_W;
   localparam int RND_SH   = NORM_FRAC + 1;
   localparam int SHIFT_W  = TWICE_W - RND_SH;

   localparam logic [TWICE_W-1:0] RND_HALF = TWICE_W'(1) << NORM_FRAC;
   localparam logic [SHIFT_W-1:0] PEN_MAX  = SHIFT_W'({PEN_W{1'b1}});

   typedef logic signed [DIST_W-1:0]  dist_type;
   typedef logic signed [TWICE_W-1:0] twice_type;

   // Load enables of the four pipeline stages.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

endpackage

`default_nettype wire

FILE: design/cpi_req_if.sv
`default_nettype none

interface cpi_req_if import cpi_pkg::*; ;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] end_a_x;
   logic signed [COORD_W-1:0] end_a_y;
   logic signed [COORD_W-1:0] end_a_z;
   logic signed [COORD_W-1:0] end_b_x;
   logic signed [COORD_W-1:0] end_b_y;
   logic signed [COORD_W-1:0] end_b_z;
   logic        [RAD_W-1:0]   radius;
   logic signed [NORM_W-1:0]  normal_x;
   logic signed [NORM_W-1:0]  normal_y;
   logic signed [NORM_W-1:0]  normal_z;
   logic signed [COORD_W-1:0] plane_offset;

   modport source (
      output valid, end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z,
             radius, normal_x, normal_y, normal_z, plane_offset,
      input  ready
   );
   modport sink (
      input  valid, end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z,
             radius, normal_x, normal_y, normal_z, plane_offset,
      output ready
   );
endinterface

`default_nettype wire

FILE: design/cpi_rsp_if.sv
`default_nettype none

interface cpi_rsp_if import cpi_pkg::*; ;
   logic             valid;
   logic             ready;
   logic             hit;
   logic [PEN_W-1:0] penetration;

   modport source (output valid, hit, penetration, input ready);
   modport sink   (input valid, hit, penetration, output ready);
endinterface

`default_nettype wire

FILE: design/cpi_dot.sv
`default_nettype none

module cpi_dot import cpi_pkg::*; (
   input  wire logic                      clock,
   input  wire stage_en_type              en,
   input  wire logic signed [COORD_W-1:0] p_x,
   input  wire logic signed [COORD_W-1:0] p_y,
   input  wire logic signed [COORD_W-1:0] p_z,
   input  wire logic signed [NORM_W-1:0]  n_x,
   input  wire logic signed [NORM_W-1:0]  n_y,
   input  wire logic signed [NORM_W-1:0]  n_z,
   input  wire logic signed [COORD_W-1:0] offset,
   output dist_type                       distance
);

   logic signed [PROD_W-1:0]  prod_x_ff, prod_x_in;
   logic signed [PROD_W-1:0]  prod_y_ff, prod_y_in;
   logic signed [PROD_W-1:0]  prod_z_ff, prod_z_in;
   logic signed [COORD_W-1:0] offset_ff;
   dist_type                  dist_ff, dist_in;

   assign prod_x_in = PROD_W'(p_x * n_x);
   assign prod_y_in = PROD_W'(p_y * n_y);
   assign prod_z_in = PROD_W'(p_z * n_z);

   // The offset is scaled by the normal's fraction so both sides share one scale.
   assign dist_in = DIST_W'(prod_x_ff) + DIST_W'(prod_y_ff) + DIST_W'(prod_z_ff)
                  - {{(DIST_W-COORD_W-NORM_FRAC){offset_ff[COORD_W-1]}}, offset_ff,
                     {NORM_FRAC{1'b0}}};

   always_ff @(posedge clock) begin
      if (en.s1) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
         offset_ff <= offset;
      end
      if (en.s2) begin
         dist_ff <= dist_in;
      end
   end

   assign distance = dist_ff;

endmodule

`default_nettype wire

FILE: design/cpi_resolve.sv
`default_nettype none

module cpi_resolve import cpi_pkg::*; (
   input  wire logic             clock,
   input  wire stage_en_type     en,
   input  wire dist_type         dist_a,
   input  wire dist_type         dist_b,
   input  wire logic [RAD_W-1:0] radius,
   output logic                  hit,
   output logic [PEN_W-1:0]      penetration
);

   dist_type         lo, hi, r_scaled;
   twice_type        lo_w, hi_w, r_w;
   logic             hit3_ff, hit3_in;
   twice_type        twice_ff, twice_in;
   logic [TWICE_W-1:0] rounded;
   logic [SHIFT_W-1:0] shifted;
   logic             hit_ff;
   logic [PEN_W-1:0] pen_ff, pen_in;

   always_comb begin
      if (dist_a < dist_b) begin
         lo = dist_a;
         hi = dist_b;
      end else begin
         lo = dist_b;
         hi = dist_a;
      end
   end

   assign r_scaled = $signed({{(DIST_W-RAD_W-NORM_FRAC){1'b0}}, radius, {NORM_FRAC{1'b0}}});
   assign lo_w     = TWICE_W'(lo);
   assign hi_w     = TWICE_W'(hi);
   assign r_w      = TWICE_W'(r_scaled);

   assign hit3_in = !((lo > r_scaled) || (hi < -r_scaled));

   // The depth is formed at twice its value so that half the spread stays exact.
   always_comb begin
      if (!lo[DIST_W-1] && !hi[DIST_W-1]) begin
         twice_in = (r_w - lo_w) <<< 1;
      end else if ((lo[DIST_W-1] || lo == '0) && (hi[DIST_W-1] || hi == '0)) begin
         twice_in = (r_w + hi_w) <<< 1;
      end else begin
         twice_in = (r_w <<< 1) + (hi_w - lo_w);
      end
   end

   assign rounded = twice_ff[TWICE_W-1] ? '0 : $unsigned(twice_ff) + RND_HALF;
   assign shifted = rounded[TWICE_W-1:RND_SH];

   always_comb begin
      if (!hit3_ff) begin
         pen_in = '0;
      end else if (shifted > PEN_MAX) begin
         pen_in = PEN_MAX[PEN_W-1:0];
      end else begin
         pen_in = shifted[PEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         hit3_ff  <= hit3_in;
         twice_ff <= twice_in;
      end
      if (en.s4) begin
         hit_ff <= hit3_ff;
         pen_ff <= pen_in;
      end
   end

   assign hit         = hit_ff;
   assign penetration = pen_ff;

endmodule

`default_nettype wire

FILE: design/capsule_plane_intersect.sv
// An accepted request word passes the product, distance, depth and output registers to become its response word.
// Throughput: one word per cycle while rsp_ch.ready does not stall it; each of the four stages holds one test.
// The stages are products, plane distances, depth forming, then round and saturate.
// Reset clears the stage valid bits only; data registers keep their contents.
`default_nettype none

module capsule_plane_intersect import cpi_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   cpi_req_if.sink   req_ch,
   cpi_rsp_if.source rsp_ch
);

   logic [3:0]       valid_ff, valid_in;
   stage_en_type     en;
   logic [RAD_W-1:0] rad1_ff, rad2_ff;
   dist_type         dist_a, dist_b;

   // A stage loads when it is empty or its word moves on.
   assign en.s4 = !valid_ff[3] || rsp_ch.ready;
   assign en.s3 = !valid_ff[2] || en.s4;
   assign en.s2 = !valid_ff[1] || en.s3;
   assign en.s1 = !valid_ff[0] || en.s2;

   assign req_ch.ready = en.s1;

   always_comb begin
      valid_in = valid_ff;
      if (en.s1) valid_in[0] = req_ch.valid;
      if (en.s2) valid_in[1] = valid_ff[0];
      if (en.s3) valid_in[2] = valid_ff[1];
      if (en.s4) valid_in[3] = valid_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) rad1_ff <= req_ch.radius;
      if (en.s2) rad2_ff <= rad1_ff;
   end

   cpi_dot u_dot_a (
      .clock    (clock),
      .en       (en),
      .p_x      (req_ch.end_a_x),
      .p_y      (req_ch.end_a_y),
      .p_z      (req_ch.end_a_z),
      .n_x      (req_ch.normal_x),
      .n_y      (req_ch.normal_y),
      .n_z      (req_ch.normal_z),
      .offset   (req_ch.plane_offset),
      .distance (dist_a)
   );

   cpi_dot u_dot_b (
      .clock    (clock),
      .en       (en),
      .p_x      (req_ch.end_b_x),
      .p_y      (req_ch.end_b_y),
      .p_z      (req_ch.end_b_z),
      .n_x      (req_ch.normal_x),
      .n_y      (req_ch.normal_y),
      .n_z      (req_ch.normal_z),
      .offset   (req_ch.plane_offset),
      .distance (dist_b)
   );

   cpi_resolve u_resolve (
      .clock       (clock),
      .en          (en),
      .dist_a      (dist_a),
      .dist_b      (dist_b),
      .radius      (rad2_ff),
      .hit         (rsp_ch.hit),
      .penetration (rsp_ch.penetration)
   );

   assign rsp_ch.valid = valid_ff[3];

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.hit |-> rsp_ch.penetration == '0)
      else $error("miss reported with non-zero penetration");

   a_room_ready: assert property (@(posedge clock) disable iff (reset)
      valid_ff != 4'b1111 |-> req_ch.ready)
      else $error("request refused while the pipeline has a free stage");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] && !en.s3 |=> valid_ff[2])
      else $error("stalled depth stage lost its word");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] && en.s4 |=> valid_ff[3])
      else $error("word did not reach the output stage");

endmodule

`default_nettype wire
